FILE: hw/rtl/kvt_pkg.sv
// Shared types and constants for the key/value table.
`timescale 1ns / 1ps

package kvt_pkg;

    localparam int KVT_ENTRIES = 16;
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;
    localparam int CNT_OUT_W   = 5;

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [1:0]              op;
        logic signed [KEY_W-1:0] key;
        logic [VAL_W-1:0]        value;
    } t_in_item;

    typedef struct packed {
        logic                 found;
        logic [VAL_W-1:0]     value_out;
        logic [1:0]           status;
        logic [CNT_OUT_W-1:0] entry_count;
    } t_out_item;

    // One key store word: valid mark above the key bits.
    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
    } t_slot;

    typedef struct packed {
        logic hit;
        logic free;
    } t_scan_flags;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_EXEC,
        S_RESULT
    } t_state;

endpackage

FILE: hw/rtl/kvt_scan.sv
// Match and free-slot tracker fed by the key store read data during a scan.
`timescale 1ns / 1ps

module kvt_scan
    import kvt_pkg::*;
#(
    parameter int AW = 4
) (
    input  logic              i_clk,
    input  logic              i_start,
    input  logic              i_cmp,
    input  logic [AW-1:0]     i_idx,
    input  t_slot             i_slot,
    input  logic [KEY_W-1:0]  i_key,
    output t_scan_flags       o_flags,
    output logic [AW-1:0]     o_hit_idx,
    output logic [AW-1:0]     o_free_idx
);

    logic          r_hit;
    logic          r_free;
    logic [AW-1:0] r_hit_idx;
    logic [AW-1:0] r_free_idx;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_hit  <= 1'b0;
            r_free <= 1'b0;
        end else if (i_cmp) begin
            if (i_slot.valid && (i_slot.key == i_key)) begin
                r_hit     <= 1'b1;
                r_hit_idx <= i_idx;
            end
            // keep the lowest free slot
            if (!i_slot.valid && !r_free) begin
                r_free     <= 1'b1;
                r_free_idx <= i_idx;
            end
        end
    end

    assign o_flags    = '{hit: r_hit, free: r_free};
    assign o_hit_idx  = r_hit_idx;
    assign o_free_idx = r_free_idx;

endmodule

FILE: hw/rtl/key_value_table_core.sv
// One item at a time: the key store is read one slot per cycle over a full scan,
// then the drain state compares the last slot, the exec state writes back, the result
// state loads the result once the output register is free, and the table returns to
// idle before the next item is taken.
// Reset: synchronous, active low; a clearing pass then zeroes the key store,
// one slot per cycle, while no item is accepted.
`timescale 1ns / 1ps

module key_value_table_core
    import kvt_pkg::*;
#(
    parameter int ENTRIES = KVT_ENTRIES
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int EW = (CW > CNT_OUT_W) ? CW : CNT_OUT_W;
    localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(ENTRIES);

    t_state r_state, n_state;

    logic [AW-1:0]    r_addr;
    t_in_item         r_req;
    logic [CW-1:0]    r_count;
    logic             r_cmp;
    logic [AW-1:0]    r_cmp_idx;
    logic             r_out_vld;
    t_out_item        r_out;

    t_slot            r_kmem [ENTRIES];
    logic [VAL_W-1:0] r_vmem [ENTRIES];
    t_slot            r_kmem_rd;
    logic [VAL_W-1:0] r_vmem_rd;

    t_scan_flags      flags;
    logic [AW-1:0]    hit_idx;
    logic [AW-1:0]    free_idx;

    logic             accept;
    logic             out_load;
    logic             kmem_we;
    logic [AW-1:0]    kmem_waddr;
    t_slot            kmem_wdata;
    logic             vmem_we;
    logic [AW-1:0]    vmem_waddr;
    logic             cnt_inc;
    logic             cnt_dec;
    logic             is_lookup;
    t_out_item        result;
    logic [EW-1:0]    count_ext;

    assign accept    = i_valid && o_ready;
    assign is_lookup = (r_req.op != OP_INSERT) && (r_req.op != OP_REMOVE);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:  if (r_addr == LAST) n_state = S_IDLE;
            S_IDLE:   if (i_valid) n_state = S_SCAN;
            S_SCAN:   if (r_addr == LAST) n_state = S_DRAIN;
            S_DRAIN:  n_state = S_EXEC;
            S_EXEC:   n_state = S_RESULT;
            S_RESULT: if (!r_out_vld || i_ready) n_state = S_IDLE;
            default:  n_state = S_CLEAR;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_ready    = 1'b0;
        out_load   = 1'b0;
        kmem_we    = 1'b0;
        kmem_waddr = r_addr;
        kmem_wdata = '0;
        vmem_we    = 1'b0;
        vmem_waddr = hit_idx;
        cnt_inc    = 1'b0;
        cnt_dec    = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                kmem_we = 1'b1;
            end
            S_IDLE: begin
                o_ready = 1'b1;
            end
            S_EXEC: begin
                if (r_req.op == OP_INSERT) begin
                    if (flags.hit) begin
                        vmem_we = 1'b1;
                    end else if (flags.free) begin
                        kmem_we    = 1'b1;
                        kmem_waddr = free_idx;
                        kmem_wdata = '{valid: 1'b1, key: r_req.key};
                        vmem_we    = 1'b1;
                        vmem_waddr = free_idx;
                        cnt_inc    = 1'b1;
                    end
                end else if (r_req.op == OP_REMOVE && flags.hit) begin
                    kmem_we    = 1'b1;
                    kmem_waddr = hit_idx;
                    kmem_wdata = '{valid: 1'b0, key: r_req.key};
                    cnt_dec    = 1'b1;
                end
            end
            S_RESULT: begin
                out_load = !r_out_vld || i_ready;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_addr    <= '0;
            r_count   <= '0;
            r_cmp     <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cmp   <= (r_state == S_SCAN);
            if (accept) begin
                r_addr <= '0;
            end else if ((r_state == S_CLEAR || r_state == S_SCAN) && r_addr != LAST) begin
                r_addr <= r_addr + AW'(1);
            end
            if (cnt_inc) begin
                r_count <= r_count + CW'(1);
            end else if (cnt_dec) begin
                r_count <= r_count - CW'(1);
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_item;
        end
        r_cmp_idx <= r_addr;
        if (out_load) begin
            r_out <= result;
        end
    end

    // key store: valid mark and key, one read per cycle along the scan
    always_ff @(posedge i_clk) begin
        if (kmem_we) begin
            r_kmem[kmem_waddr] <= kmem_wdata;
        end
        r_kmem_rd <= r_kmem[r_addr];
    end

    // value store: read at the matched slot for a lookup
    always_ff @(posedge i_clk) begin
        if (vmem_we) begin
            r_vmem[vmem_waddr] <= r_req.value;
        end
        r_vmem_rd <= r_vmem[hit_idx];
    end

    kvt_scan #(
        .AW(AW)
    ) u_scan (
        .i_clk      (i_clk),
        .i_start    (accept),
        .i_cmp      (r_cmp),
        .i_idx      (r_cmp_idx),
        .i_slot     (r_kmem_rd),
        .i_key      (r_req.key),
        .o_flags    (flags),
        .o_hit_idx  (hit_idx),
        .o_free_idx (free_idx)
    );

    assign count_ext = EW'(r_count);

    always_comb begin
        result.found       = flags.hit;
        result.value_out   = (is_lookup && flags.hit) ? r_vmem_rd : '0;
        result.entry_count = count_ext[CNT_OUT_W-1:0];
        if (r_req.op == OP_INSERT) begin
            result.status = (flags.hit || flags.free) ? ST_DONE : ST_FULL;
        end else begin
            result.status = flags.hit ? ST_DONE : ST_MISS;
        end
    end

    assign o_valid = r_out_vld;
    assign o_item  = r_out;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAX_CNT)
        else $error("entry count above table size");

    a_accept_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_SCAN && r_addr == '0))
        else $error("accepted item did not start a scan at slot zero");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |=> (r_count == $past(r_count)
            || r_count == $past(r_count) + CW'(1)
            || r_count == $past(r_count) - CW'(1)))
        else $error("entry count moved by more than one");

    a_free_not_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && flags.hit && flags.free) |-> (hit_idx != free_idx))
        else $error("slot reported both matched and free");

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for the key/value table core.
`timescale 1ns / 1ps

module tb_top;
    import kvt_pkg::*;

    localparam int              ENTRIES     = KVT_ENTRIES;
    localparam logic [1:0]      OP_SPARE    = 2'd3;   // unused code, acts as lookup
    localparam int              KEY_POOL    = 24;     // more keys than slots, so it fills
    localparam int              HOLD_CYCLES = 400;
    localparam int              LIMIT       = 200000;
    localparam int              MAX_REPORTS = 10;

    typedef struct {
        t_in_item  it;
        bit        typed;
        t_out_item res;
    } t_dir_row;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      i_ready = 1'b0;
    t_in_item  i_item  = '0;
    logic      o_ready;
    logic      o_valid;
    t_out_item o_item;

    key_value_table_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the table
    logic             shadow_valid [ENTRIES];
    logic [KEY_W-1:0] shadow_key   [ENTRIES];
    logic [VAL_W-1:0] shadow_value [ENTRIES];
    int               shadow_count;

    t_out_item        pending_results [$];
    t_dir_row         dir_rows [$];
    logic [KEY_W-1:0] key_pool [KEY_POOL];

    int n_items;
    int n_hits;
    int n_misses;
    int n_full;
    int n_results;
    int n_errors;
    int snd_idle_pct;
    int rcv_stall_pct;
    int hold_seq;
    int sink_seen;
    int sink_hold;

    initial begin
        for (int i = 0; i < ENTRIES; i++) begin
            shadow_valid[i] = 1'b0;
        end
        shadow_count  = 0;
        n_items       = 0;
        n_hits        = 0;
        n_misses      = 0;
        n_full        = 0;
        n_results     = 0;
        n_errors      = 0;
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        hold_seq      = 0;
        sink_seen     = 0;
        sink_hold     = 0;
    end

    // Apply one operation to the shadow table and return the result it yields.
    function automatic t_out_item table_apply(t_in_item it);
        int        hit;
        int        free_idx;
        t_out_item r;
        hit      = -1;
        free_idx = -1;
        for (int i = 0; i < ENTRIES; i++) begin
            if (hit < 0 && shadow_valid[i] && shadow_key[i] == it.key) begin
                hit = i;
            end
            if (free_idx < 0 && !shadow_valid[i]) begin
                free_idx = i;
            end
        end
        r        = '0;
        r.found  = (hit >= 0);
        r.status = ST_DONE;
        case (it.op)
            OP_INSERT: begin
                if (hit >= 0) begin
                    shadow_value[hit] = it.value;
                end else if (free_idx >= 0) begin
                    shadow_valid[free_idx] = 1'b1;
                    shadow_key[free_idx]   = it.key;
                    shadow_value[free_idx] = it.value;
                    shadow_count++;
                end else begin
                    r.status = ST_FULL;
                    n_full++;
                end
            end
            OP_REMOVE: begin
                if (hit >= 0) begin
                    shadow_valid[hit] = 1'b0;
                    if (shadow_count > 0) begin
                        shadow_count--;
                    end
                end else begin
                    r.status = ST_MISS;
                end
            end
            default: begin
                if (hit >= 0) begin
                    r.value_out = shadow_value[hit];
                end else begin
                    r.status = ST_MISS;
                end
            end
        endcase
        if (hit >= 0) begin
            n_hits++;
        end else if (r.status == ST_MISS) begin
            n_misses++;
        end
        r.entry_count = shadow_count[CNT_OUT_W-1:0];
        return r;
    endfunction

    function automatic t_out_item res_of(logic found, logic [VAL_W-1:0] vout,
                                         logic [1:0] status, int cnt);
        t_out_item r;
        r.found       = found;
        r.value_out   = vout;
        r.status      = status;
        r.entry_count = cnt[CNT_OUT_W-1:0];
        return r;
    endfunction

    function automatic void add_row(logic [1:0] op, logic [KEY_W-1:0] key,
                                    logic [VAL_W-1:0] val, bit typed, t_out_item res);
        t_dir_row row;
        row.it.op    = op;
        row.it.key   = key;
        row.it.value = val;
        row.typed    = typed;
        row.res      = res;
        dir_rows.push_back(row);
    endfunction

    function automatic t_in_item random_op(int ins_pct);
        t_in_item it;
        int       r;
        r = $urandom_range(99);
        if (r < ins_pct) begin
            it.op = OP_INSERT;
        end else if (r < ins_pct + (95 - ins_pct) / 2) begin
            it.op = OP_LOOKUP;
        end else if (r < 95) begin
            it.op = OP_REMOVE;
        end else begin
            it.op = OP_SPARE;
        end
        // mostly keys from a small pool so hits and a full table happen
        if ($urandom_range(9) == 0) begin
            it.key = $urandom;
        end else begin
            it.key = key_pool[$urandom_range(KEY_POOL - 1)];
        end
        case ($urandom_range(7))
            0:       it.value = '0;
            1:       it.value = '1;
            default: it.value = $urandom;
        endcase
        return it;
    endfunction

    // Offer one item and hold it until accepted; record what it should yield.
    task automatic send(t_in_item it, bit typed, t_out_item res);
        t_out_item predicted;
        while ($urandom_range(99) < snd_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= it;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        predicted = table_apply(it);
        pending_results.push_back(typed ? res : predicted);
        n_items++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic run_phase(int count, int snd_pct, int rcv_pct, int ins_pct);
        snd_idle_pct   = snd_pct;
        rcv_stall_pct <= rcv_pct;
        for (int n = 0; n < count; n++) begin
            send(random_op(ins_pct), 1'b0, '0);
        end
    endtask

    // Sink: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (sink_seen != hold_seq) begin
            sink_seen <= hold_seq;
            sink_hold <= HOLD_CYCLES;
            i_ready   <= 1'b0;
        end else if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
            i_ready   <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && o_valid && i_ready) begin
            n_results++;
            if (pending_results.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS) begin
                    $display("unexpected result: found %0d value %h status %0d count %0d",
                             o_item.found, o_item.value_out, o_item.status,
                             o_item.entry_count);
                end
            end else begin
                want = pending_results.pop_front();
                if (o_item.found !== want.found || o_item.value_out !== want.value_out ||
                    o_item.status !== want.status ||
                    o_item.entry_count !== want.entry_count) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS) begin
                        $display("mismatch %0d: got found %0d value %h status %0d count %0d",
                                 n_results, o_item.found, o_item.value_out,
                                 o_item.status, o_item.entry_count);
                        $display("    want found %0d value %h status %0d count %0d",
                                 want.found, want.value_out, want.status,
                                 want.entry_count);
                    end
                end
            end
        end
    end

    initial begin
        repeat (LIMIT) @(posedge i_clk);
        $display("run stopped after %0d cycles with %0d results outstanding",
                 LIMIT, pending_results.size());
        $display("FAILURE");
        $finish;
    end

    initial begin
        for (int i = 0; i < KEY_POOL; i++) begin
            key_pool[i] = $urandom;
        end
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hFFFF_FFFF;

        // empty table, extreme keys, spare op code, update in place
        add_row(OP_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1,
                res_of(1'b0, '0, ST_MISS, 0));
        add_row(OP_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1,
                res_of(1'b0, '0, ST_MISS, 0));
        add_row(OP_SPARE,  32'h0000_0005, 32'h0000_0000, 1'b1,
                res_of(1'b0, '0, ST_MISS, 0));
        add_row(OP_INSERT, 32'h8000_0000, 32'h0000_0000, 1'b1,
                res_of(1'b0, '0, ST_DONE, 1));
        add_row(OP_INSERT, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                res_of(1'b0, '0, ST_DONE, 2));
        add_row(OP_LOOKUP, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1,
                res_of(1'b1, 32'hFFFF_FFFF, ST_DONE, 2));
        add_row(OP_SPARE,  32'h8000_0000, 32'h0000_1234, 1'b1,
                res_of(1'b1, '0, ST_DONE, 2));
        add_row(OP_INSERT, 32'h7FFF_FFFF, 32'h5A5A_5A5A, 1'b1,
                res_of(1'b1, '0, ST_DONE, 2));
        // fill the remaining slots
        for (int k = 1; k <= ENTRIES - 2; k++) begin
            add_row(OP_INSERT, k, k * 32'h1111_1111, 1'b0, '0);
        end
        add_row(OP_INSERT, 32'd100, 32'h0000_0100, 1'b1,
                res_of(1'b0, '0, ST_FULL, ENTRIES));
        add_row(OP_REMOVE, 32'd1,   32'h0000_0000, 1'b1,
                res_of(1'b1, '0, ST_DONE, ENTRIES - 1));
        add_row(OP_LOOKUP, 32'd1,   32'h0000_0000, 1'b1,
                res_of(1'b0, '0, ST_MISS, ENTRIES - 1));
        add_row(OP_INSERT, 32'd100, 32'h0000_0100, 1'b1,
                res_of(1'b0, '0, ST_DONE, ENTRIES));
        add_row(OP_LOOKUP, 32'd100, 32'h0000_0000, 1'b0, '0);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r]) begin
            send(dir_rows[r].it, dir_rows[r].typed, dir_rows[r].res);
        end

        run_phase(140, 0, 0, 55);
        run_phase(130, 62, 0, 40);

        // hold the sink off while the sender keeps offering, then let it all drain
        hold_seq <= hold_seq + 1;
        run_phase(20, 0, 0, 45);
        drain();

        run_phase(130, 0, 62, 35);
        run_phase(130, 26, 26, 45);

        drain();
        repeat (ENTRIES + 8) @(posedge i_clk);

        $display("Covered %0d items: %0d key hits, %0d misses, %0d inserts refused as full.",
                 n_items, n_hits, n_misses, n_full);
        $display("Mixes: no idling, sender idle, sink stalling, both; %0d-cycle sink hold.",
                 HOLD_CYCLES);
        if (n_errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d errors", n_errors);
            $display("FAILURE");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/kvt_pkg.sv
hw/rtl/kvt_scan.sv
hw/rtl/key_value_table_core.sv
verif/tb_top.sv
